@@ design/icogen_pkg.sv @@
// Package for the icosphere triangle index generator.
// Holds the base solid tables, the edge search function and the shared types.
// No dependencies.
package icogen_pkg;

    localparam int NUM_CORNERS  = 12;
    localparam int NUM_EDGES    = 30;
    localparam int NUM_FACES    = 20;
    localparam int FACE_W       = 5;
    localparam int ROW_W        = 5;
    localparam int DIV_W        = 6;
    localparam int CORNER_W     = 14;
    localparam int EDGE_W       = 5;
    localparam int VTX_W        = 4;

    // Each entry packs two corner numbers, lower corner in the upper nibble.
    localparam logic [7:0] EDGE_TABLE [NUM_EDGES] = '{
        8'h01, 8'h04, 8'h05, 8'h08, 8'h0A, 8'h16,
        8'h17, 8'h18, 8'h1A, 8'h23, 8'h24, 8'h25,
        8'h29, 8'h2B, 8'h36, 8'h37, 8'h39, 8'h3B,
        8'h45, 8'h48, 8'h49, 8'h5A, 8'h5B, 8'h67,
        8'h68, 8'h69, 8'h7A, 8'h7B, 8'h89, 8'hAB
    };

    localparam logic [VTX_W-1:0] FACE_TABLE [NUM_FACES][3] = '{
        '{4'd0, 4'd1, 4'd8},  '{4'd0, 4'd1, 4'd10}, '{4'd2, 4'd3, 4'd9},
        '{4'd2, 4'd3, 4'd11}, '{4'd4, 4'd8, 4'd9},  '{4'd6, 4'd8, 4'd9},
        '{4'd5, 4'd10, 4'd11}, '{4'd7, 4'd10, 4'd11}, '{4'd0, 4'd4, 4'd8},
        '{4'd1, 4'd6, 4'd8},  '{4'd2, 4'd4, 4'd9},  '{4'd3, 4'd6, 4'd9},
        '{4'd0, 4'd5, 4'd10}, '{4'd1, 4'd7, 4'd10}, '{4'd2, 4'd5, 4'd11},
        '{4'd3, 4'd7, 4'd11}, '{4'd0, 4'd4, 4'd5},  '{4'd2, 4'd4, 4'd5},
        '{4'd1, 4'd6, 4'd7},  '{4'd3, 4'd6, 4'd7}
    };

    // Position of the first edge table entry that is not below the key.
    function automatic logic [EDGE_W-1:0] edge_find(input logic [7:0] key);
        logic [EDGE_W-1:0] pos;
        pos = EDGE_W'(NUM_EDGES);
        for (int e = NUM_EDGES - 1; e >= 0; e--)
        begin
            if (EDGE_TABLE[e] >= key)
            begin
                pos = EDGE_W'(e);
            end
        end
        return pos;
    endfunction

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP0,
        S_PREP1,
        S_PREP2,
        S_PREP3,
        S_VA,
        S_VB,
        S_VC
    } state_t;

    typedef enum logic {
        UOP_MUL,
        UOP_VERT
    } unit_op_t;

    typedef struct packed {
        unit_op_t op;
        logic     row_next;
    } unit_req_t;

endpackage

@@ design/icogen_cfg.sv @@
// APB register file of the icosphere triangle index generator.
// Holds the divisions register. Depends on icogen_pkg.
module icogen_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [icogen_pkg::DIV_W-1:0]  divisions
);
    import icogen_pkg::*;

    logic [DIV_W-1:0] divisions_reg;
    logic             hit;

    // Only one register exists; it decodes to word zero.
    assign hit    = (paddr[2] == 1'b0);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisions_reg <= DIV_W'(1);
        end
        else if (psel && penable && pwrite && hit)
        begin
            divisions_reg <= pwdata[DIV_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = 32'(divisions_reg);
        end
    end

    assign divisions = divisions_reg;

endmodule

@@ design/icogen_unit.sv @@
// Shared arithmetic unit: one multiplier plus the vertex numbering adders.
// Used for setup products and for every vertex index. Depends on icogen_pkg.
module icogen_unit #(
    parameter int D_W   = 6,
    parameter int MA_W  = 6,
    parameter int CV_W  = 9,
    parameter int IDX_W = 14
) (
    input  icogen_pkg::unit_req_t            req,
    input  logic [MA_W-1:0]                  mul_a,
    input  logic [CV_W-1:0]                  mul_b,
    input  logic [D_W-1:0]                   d,
    input  logic [D_W-1:0]                   ev,
    input  logic [D_W-1:0]                   p,
    input  logic [D_W-1:0]                   col,
    input  logic [icogen_pkg::VTX_W-1:0]     ci,
    input  logic [icogen_pkg::VTX_W-1:0]     cj,
    input  logic [icogen_pkg::VTX_W-1:0]     ck,
    input  logic [icogen_pkg::EDGE_W-1:0]    e_ij,
    input  logic [icogen_pkg::EDGE_W-1:0]    e_ik,
    input  logic [icogen_pkg::EDGE_W-1:0]    e_jk,
    input  logic [IDX_W-1:0]                 base,
    input  logic [CV_W-1:0]                  row_ofs0,
    input  logic [CV_W-1:0]                  row_ofs1,
    output logic [MA_W+CV_W-1:0]             prod,
    output logic [IDX_W-1:0]                 idx
);
    import icogen_pkg::*;

    localparam int PROD_W = MA_W + CV_W;

    logic [D_W-1:0]    r;
    logic              side;
    logic              on_edge;
    logic [EDGE_W-1:0] e_sel;
    logic [MA_W-1:0]   op_a;
    logic [CV_W-1:0]   op_b;
    logic [IDX_W-1:0]  edge_idx;
    logic [IDX_W-1:0]  int_idx;

    assign r       = p + D_W'(req.row_next);
    assign side    = (r == d);
    assign on_edge = (col == '0) || (col == r) || side;
    assign e_sel   = side ? e_jk : ((col == '0) ? e_ij : e_ik);

    always_comb
    begin
        unique case (req.op)
            UOP_VERT:
            begin
                op_a = MA_W'(e_sel);
                op_b = CV_W'(ev);
            end
            default:
            begin
                op_a = mul_a;
                op_b = mul_b;
            end
        endcase
    end

    assign prod = PROD_W'(op_a) * PROD_W'(op_b);

    // Edge points are counted from the lower numbered corner of their edge.
    assign edge_idx = IDX_W'(NUM_CORNERS) + IDX_W'(prod)
                    + IDX_W'(side ? col : r) - IDX_W'(1);
    assign int_idx  = base + IDX_W'(req.row_next ? row_ofs1 : row_ofs0)
                    + IDX_W'(col) - IDX_W'(1);

    always_comb
    begin
        priority if (r == '0 && col == '0)
        begin
            idx = IDX_W'(ci);
        end
        else if (side && col == '0)
        begin
            idx = IDX_W'(cj);
        end
        else if (side && col == d)
        begin
            idx = IDX_W'(ck);
        end
        else if (on_edge)
        begin
            idx = edge_idx;
        end
        else
        begin
            idx = int_idx;
        end
    end

endmodule

@@ design/icosphere_triangle_index_gen_top.sv @@
// Top level of the icosphere triangle index generator.
// Instantiates icogen_cfg and icogen_unit and holds the sequencer. Depends on icogen_pkg.
//
// A command word (face, row) is taken when start is high and busy is low. For a
// valid row the block raises busy and emits the row's 2*row+1 triangles, one per
// result word, each marked by a one-cycle valid pulse; the final word has last set.
// The receiver cannot stall, so every valid pulse must be captured. Vertex indices
// are numbered corners first, then the points along each of the 30 base edges, then
// the interior points of each face. Every vertex index and the setup triangle-number
// products come from one shared unit with one small multiplier: after the accept, setup
// states S_PREP0 to S_PREP3 compute the per-face and per-row bases and look up the edges
// ij, ik and jk; each triangle then runs S_VA, S_VB and S_VC for vertices a, b and c. The
// block stays busy, taking no new command, until the row's last triangle is done, and
// the first result word is registered as the first S_VC state ends. A row at or beyond
// the division count produces a single word with bad_row and last set on the cycle
// after the accept, and busy does not rise. Face numbers above 19 wrap by 20, and a
// divisions value above MAX_DIVISIONS acts as MAX_DIVISIONS. Write divisions only
// while busy is low and no result is pending.
module icosphere_triangle_index_gen_top #(
    parameter int MAX_DIVISIONS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [icogen_pkg::FACE_W-1:0]     face,
    input  logic [icogen_pkg::ROW_W-1:0]      row,
    output logic                              valid,
    output logic [icogen_pkg::CORNER_W-1:0]   corner_a,
    output logic [icogen_pkg::CORNER_W-1:0]   corner_b,
    output logic [icogen_pkg::CORNER_W-1:0]   corner_c,
    output logic                              last,
    output logic                              bad_row
);
    import icogen_pkg::*;

    // Division count width, multiplier operand widths and the internal index width.
    localparam int D_W    = $clog2(MAX_DIVISIONS + 1);
    localparam int MA_W   = (D_W > FACE_W) ? D_W : FACE_W;
    localparam int CV_W   = $clog2(MAX_DIVISIONS * MAX_DIVISIONS / 2 + 1);
    localparam int PROD_W = MA_W + CV_W;
    localparam int IDX_W  = $clog2(NUM_CORNERS + NUM_EDGES * MAX_DIVISIONS
                                   + NUM_FACES * MAX_DIVISIONS * MAX_DIVISIONS / 2 + 1);

    logic [DIV_W-1:0]  divisions;
    logic [D_W-1:0]    d_cur;
    logic [FACE_W-1:0] face_w;
    logic              accept;
    logic              row_bad;
    logic              swap_cur;

    state_t            state_reg;
    state_t            state_next;

    logic [D_W-1:0]    q_reg;
    logic              half_reg;
    logic              valid_reg;

    logic [D_W-1:0]    d_reg;
    logic [D_W-1:0]    p_reg;
    logic [FACE_W-1:0] f_reg;
    logic              swap_reg;
    logic [VTX_W-1:0]  ci_reg;
    logic [VTX_W-1:0]  cj_reg;
    logic [VTX_W-1:0]  ck_reg;
    logic [EDGE_W-1:0] e_ij_reg;
    logic [EDGE_W-1:0] e_ik_reg;
    logic [EDGE_W-1:0] e_jk_reg;
    logic [CV_W-1:0]   cv_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [CV_W-1:0]   tri0_reg;
    logic [CV_W-1:0]   tri1_reg;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  b_reg;

    logic [CORNER_W-1:0] corner_a_reg;
    logic [CORNER_W-1:0] corner_b_reg;
    logic [CORNER_W-1:0] corner_c_reg;
    logic                last_reg;
    logic                bad_row_reg;

    logic [D_W-1:0]    ev;
    logic              last_tri;

    unit_req_t         req;
    logic [MA_W-1:0]   mul_a;
    logic [CV_W-1:0]   mul_b;
    logic [D_W-1:0]    col;
    logic [7:0]        key;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx;

    icogen_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .divisions (divisions)
    );

    icogen_unit #(
        .D_W   (D_W),
        .MA_W  (MA_W),
        .CV_W  (CV_W),
        .IDX_W (IDX_W)
    ) u_unit (
        .req      (req),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .d        (d_reg),
        .ev       (ev),
        .p        (p_reg),
        .col      (col),
        .ci       (ci_reg),
        .cj       (cj_reg),
        .ck       (ck_reg),
        .e_ij     (e_ij_reg),
        .e_ik     (e_ik_reg),
        .e_jk     (e_jk_reg),
        .base     (base_reg),
        .row_ofs0 (tri0_reg),
        .row_ofs1 (tri1_reg),
        .prod     (prod),
        .idx      (idx)
    );

    // Saturate the division count and wrap the face number at the command boundary.
    assign d_cur    = (int'(divisions) > MAX_DIVISIONS) ? D_W'(MAX_DIVISIONS)
                                                       : D_W'(divisions);
    assign face_w   = (face >= FACE_W'(NUM_FACES)) ? face - FACE_W'(NUM_FACES) : face;
    assign accept   = start && (state_reg == S_IDLE);
    assign row_bad  = (MA_W'(row) >= MA_W'(d_cur));
    // Faces whose winding is swapped so all triangles keep one orientation.
    assign swap_cur = ((face_w[1:0] == 2'd1) || (face_w[1:0] == 2'd2))
                      != ((face_w >= FACE_W'(8)) && (face_w < FACE_W'(12)));

    assign ev       = d_reg - D_W'(1);
    assign last_tri = !half_reg && (q_reg == p_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !row_bad)
                begin
                    state_next = S_PREP0;
                end
            end
            S_PREP0: state_next = S_PREP1;
            S_PREP1: state_next = S_PREP2;
            S_PREP2: state_next = S_PREP3;
            S_PREP3: state_next = S_VA;
            S_VA:    state_next = S_VB;
            S_VB:    state_next = S_VC;
            S_VC:    state_next = last_tri ? S_IDLE : S_VA;
            default: state_next = S_IDLE;
        endcase
    end

    // Requests to the shared unit for each state.
    always_comb
    begin
        req.op       = UOP_MUL;
        req.row_next = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        col          = q_reg;
        key          = {ci_reg, cj_reg};
        unique case (state_reg)
            S_PREP0:
            begin
                mul_a = MA_W'(d_reg - D_W'(2));
                mul_b = CV_W'(d_reg - D_W'(1));
                key   = {ci_reg, cj_reg};
            end
            S_PREP1:
            begin
                mul_a = MA_W'(f_reg);
                mul_b = cv_reg;
                key   = {ci_reg, ck_reg};
            end
            S_PREP2:
            begin
                mul_a = MA_W'(p_reg - D_W'(2));
                mul_b = CV_W'(p_reg - D_W'(1));
                key   = {cj_reg, ck_reg};
            end
            S_PREP3:
            begin
                mul_a = MA_W'(p_reg - D_W'(1));
                mul_b = CV_W'(p_reg);
            end
            S_VA:
            begin
                req.op = UOP_VERT;
            end
            S_VB:
            begin
                req.op = UOP_VERT;
                if (half_reg)
                begin
                    req.row_next = swap_reg;
                    col          = q_reg + D_W'(1);
                end
                else
                begin
                    req.row_next = 1'b1;
                    col          = q_reg + D_W'(!swap_reg);
                end
            end
            S_VC:
            begin
                req.op = UOP_VERT;
                if (half_reg)
                begin
                    req.row_next = !swap_reg;
                    col          = q_reg + D_W'(1);
                end
                else
                begin
                    req.row_next = 1'b1;
                    col          = q_reg + D_W'(swap_reg);
                end
            end
            default:
            begin
                req.op = UOP_MUL;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            q_reg     <= '0;
            half_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (accept && row_bad) || (state_reg == S_VC);
            if (accept)
            begin
                q_reg    <= '0;
                half_reg <= 1'b0;
            end
            else if (state_reg == S_VC)
            begin
                if (half_reg)
                begin
                    half_reg <= 1'b0;
                    q_reg    <= q_reg + D_W'(1);
                end
                else
                begin
                    half_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg    <= d_cur;
            p_reg    <= D_W'(row);
            f_reg    <= face_w;
            swap_reg <= swap_cur;
            ci_reg   <= FACE_TABLE[face_w][0];
            cj_reg   <= FACE_TABLE[face_w][1];
            ck_reg   <= FACE_TABLE[face_w][2];
            if (row_bad)
            begin
                corner_a_reg <= '0;
                corner_b_reg <= '0;
                corner_c_reg <= '0;
                last_reg     <= 1'b1;
                bad_row_reg  <= 1'b1;
            end
        end
        unique case (state_reg)
            S_PREP0:
            begin
                cv_reg   <= (d_reg >= D_W'(2)) ? CV_W'(prod >> 1) : '0;
                e_ij_reg <= edge_find(key);
            end
            S_PREP1:
            begin
                base_reg <= IDX_W'(NUM_CORNERS) + IDX_W'(NUM_EDGES) * IDX_W'(ev)
                          + IDX_W'(prod);
                e_ik_reg <= edge_find(key);
            end
            S_PREP2:
            begin
                tri0_reg <= (p_reg >= D_W'(2)) ? CV_W'(prod >> 1) : '0;
                e_jk_reg <= edge_find(key);
            end
            S_PREP3:
            begin
                tri1_reg <= (p_reg >= D_W'(1)) ? CV_W'(prod >> 1) : '0;
            end
            S_VA:
            begin
                a_reg <= idx;
            end
            S_VB:
            begin
                b_reg <= idx;
            end
            S_VC:
            begin
                corner_a_reg <= CORNER_W'(a_reg);
                corner_b_reg <= CORNER_W'(b_reg);
                corner_c_reg <= CORNER_W'(idx);
                last_reg     <= last_tri;
                bad_row_reg  <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign valid    = valid_reg;
    assign corner_a = corner_a_reg;
    assign corner_b = corner_b_reg;
    assign corner_c = corner_c_reg;
    assign last     = last_reg;
    assign bad_row  = bad_row_reg;

endmodule

@@ verif/icosphere_triangle_index_gen_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for icosphere_triangle_index_gen_top: drives (face, row) command
// words and the divisions register, and checks every triangle word against its own model.
// Depends on icogen_pkg and the design files; stands alone otherwise.
module icosphere_triangle_index_gen_top_tb;

    // ---------------------------------------------------------------------------------
    // Sizes and codes
    // ---------------------------------------------------------------------------------
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_DIV       = 32;
    localparam int IDX_W         = icogen_pkg::CORNER_W;
    localparam int FACE_BITS     = icogen_pkg::FACE_W;
    localparam int ROW_BITS      = icogen_pkg::ROW_W;

    // Vertex numbering groups of the base solid.
    localparam int CORNERS = 12;
    localparam int EDGES   = 30;
    localparam int FACES   = 20;

    // Register map: the only register is divisions, at index 0. Index 1 does not exist
    // and a write there must leave the block untouched.
    localparam int         REG_DIVISIONS  = 0;
    localparam logic [2:0] ADDR_DIVISIONS = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

    // Cycles to let pass after the last expected word before touching the register, and
    // after the whole run (longer than the longest row keeps the block busy).
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 200;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int WORDS_PER_SETTING = 31;

    // Each edge key packs its two corners, lower corner in the upper nibble, sorted.
    localparam logic [0:EDGES-1][7:0] EDGE_KEYS = '{
        8'h01, 8'h04, 8'h05, 8'h08, 8'h0A, 8'h16,
        8'h17, 8'h18, 8'h1A, 8'h23, 8'h24, 8'h25,
        8'h29, 8'h2B, 8'h36, 8'h37, 8'h39, 8'h3B,
        8'h45, 8'h48, 8'h49, 8'h5A, 8'h5B, 8'h67,
        8'h68, 8'h69, 8'h7A, 8'h7B, 8'h89, 8'hAB
    };

    // The three corners of each base face, in the order the rows are walked.
    localparam logic [0:FACES-1][0:2][3:0] FACE_CORNERS = '{
        '{4'd0, 4'd1, 4'd8},  '{4'd0, 4'd1, 4'd10}, '{4'd2, 4'd3, 4'd9},
        '{4'd2, 4'd3, 4'd11}, '{4'd4, 4'd8, 4'd9},  '{4'd6, 4'd8, 4'd9},
        '{4'd5, 4'd10, 4'd11}, '{4'd7, 4'd10, 4'd11}, '{4'd0, 4'd4, 4'd8},
        '{4'd1, 4'd6, 4'd8},  '{4'd2, 4'd4, 4'd9},  '{4'd3, 4'd6, 4'd9},
        '{4'd0, 4'd5, 4'd10}, '{4'd1, 4'd7, 4'd10}, '{4'd2, 4'd5, 4'd11},
        '{4'd3, 4'd7, 4'd11}, '{4'd0, 4'd4, 4'd5},  '{4'd2, 4'd4, 4'd5},
        '{4'd1, 4'd6, 4'd7},  '{4'd3, 4'd6, 4'd7}
    };

    // One result word: a triangle, or the error word of an out-of-range row.
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             last;
        logic             bad;
    } tri_word_t;

    // ---------------------------------------------------------------------------------
    // Scoreboard: holds its own copy of divisions, expands each accepted command into the
    // triangle words it must produce and compares the words that come out, in order.
    // ---------------------------------------------------------------------------------
    class row_scoreboard;
        tri_word_t  expected_words[$];
        logic [5:0] divisions;
        int         errors;
        int         commands;
        int         bad_rows;
        int         words_checked;
        int         settings;

        function new();
            divisions     = 6'd1;
            errors        = 0;
            commands      = 0;
            bad_rows      = 0;
            words_checked = 0;
            settings      = 0;
        endfunction

        // The register keeps six bits; anything above MAX_DIV behaves as MAX_DIV.
        function void set_divisions(logic [31:0] value);
            divisions = value[5:0];
            settings++;
        endfunction

        function int effective_divisions();
            return (divisions > MAX_DIV) ? MAX_DIV : int'(divisions);
        endfunction

        function int edge_slot(int key);
            for (int e = 0; e < EDGES; e++)
            begin
                if (int'(EDGE_KEYS[e]) >= key)
                    return e;
            end
            return EDGES;
        endfunction

        // Index of the lattice point (p, q) of face f, where p counts rows from the first
        // corner and q runs from 0 to p. Corners come first, then edge points counted from
        // the lower corner of each edge, then the interior points of each face.
        function int vertex_number(int f, int d, int p, int q);
            int  ci;
            int  cj;
            int  ck;
            int  per_edge;
            int  per_face;
            int  from_c;
            int  to_c;
            bit  far_side;
            ci       = FACE_CORNERS[f][0];
            cj       = FACE_CORNERS[f][1];
            ck       = FACE_CORNERS[f][2];
            per_edge = d - 1;
            per_face = (d >= 2) ? (d - 2) * (d - 1) / 2 : 0;
            if (p == 0 && q == 0)
                return ci;
            if (p == d && q == 0)
                return cj;
            if (p == d && q == d)
                return ck;
            if (q == 0 || q == p || p == d)
            begin
                far_side = (p == d);
                from_c   = far_side ? cj : ci;
                to_c     = (q != 0) ? ck : cj;
                return CORNERS + edge_slot(from_c * 16 + to_c) * per_edge
                       + (far_side ? q : p) - 1;
            end
            return CORNERS + EDGES * per_edge + f * per_face + (p - 2) * (p - 1) / 2 + (q - 1);
        endfunction

        function void push_word(int a, int b, int c, bit is_last, bit is_bad);
            tri_word_t w;
            w.a    = IDX_W'(a);
            w.b    = IDX_W'(b);
            w.c    = IDX_W'(c);
            w.last = is_last;
            w.bad  = is_bad;
            expected_words.push_back(w);
        endfunction

        // Called at the clock edge that accepts a command word.
        function void note_command(logic [FACE_BITS-1:0] face_in, logic [ROW_BITS-1:0] row_in);
            int f;
            int p;
            int d;
            int s;
            int ns;
            int a;
            f = int'(face_in);
            p = int'(row_in);
            d = effective_divisions();
            commands++;
            if (f >= FACES)
                f -= FACES;
            if (p >= d)
            begin
                bad_rows++;
                push_word(0, 0, 0, 1'b1, 1'b1);
                return;
            end
            // Some faces are walked with the winding swapped so all triangles face out.
            s  = (((f % 4 == 1) || (f % 4 == 2)) != (f >= 8 && f < 12)) ? 1 : 0;
            ns = s ^ 1;
            for (int q = 0; q < p; q++)
            begin
                a = vertex_number(f, d, p, q);
                push_word(a, vertex_number(f, d, p + 1, q + ns),
                          vertex_number(f, d, p + 1, q + s), 1'b0, 1'b0);
                push_word(a, vertex_number(f, d, p + s, q + 1),
                          vertex_number(f, d, p + ns, q + 1), 1'b0, 1'b0);
            end
            push_word(vertex_number(f, d, p, p), vertex_number(f, d, p + 1, p + ns),
                      vertex_number(f, d, p + 1, p + s), 1'b1, 1'b0);
        endfunction

        function void report_field(string field, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch on word %0d, expected %0d, actual %0d",
                         $time, field, words_checked, want, got);
            end
        endfunction

        // Called at the clock edge that ends a cycle with valid high.
        function void check_word(tri_word_t got);
            tri_word_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %0d %0d %0d %s%0b %s%0b",
                         $time, got.a, got.b, got.c, "last=", got.last, "bad=", got.bad);
                return;
            end
            want = expected_words.pop_front();
            report_field("corner_a", want.a, got.a);
            report_field("corner_b", want.b, got.b);
            report_field("corner_c", want.c, got.c);
            report_field("last", IDX_W'(want.last), IDX_W'(got.last));
            report_field("bad_row", IDX_W'(want.bad), IDX_W'(got.bad));
            words_checked++;
        endfunction

        function void close_out();
            if (expected_words.size() != 0)
            begin
                errors += expected_words.size();
                $display("%0t: %0d expected words never arrived, next expected %0d %0d %0d",
                         $time, expected_words.size(), expected_words[0].a,
                         expected_words[0].b, expected_words[0].c);
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------------------
    // Signals. Every input of the block has a known value from time zero.
    // ---------------------------------------------------------------------------------
    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [2:0]           paddr   = 3'd0;
    logic [31:0]          pwdata  = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start   = 1'b0;
    logic                 busy;
    logic [FACE_BITS-1:0] face    = '0;
    logic [ROW_BITS-1:0]  row     = '0;
    logic                 valid;
    logic [IDX_W-1:0]     corner_a;
    logic [IDX_W-1:0]     corner_b;
    logic [IDX_W-1:0]     corner_c;
    logic                 last;
    logic                 bad_row;

    row_scoreboard board = new();
    int            cycles = 0;

    icosphere_triangle_index_gen_top #(
        .MAX_DIVISIONS(MAX_DIV)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .face     (face),
        .row      (row),
        .valid    (valid),
        .corner_a (corner_a),
        .corner_b (corner_b),
        .corner_c (corner_c),
        .last     (last),
        .bad_row  (bad_row)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a correct run ends well inside this many cycles, so reaching it means a
    // hang or lost words.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("** icosphere_triangle_index_gen_top: FAILED **");
            $finish;
        end
    end

    // Result monitor. The receiver cannot stall, so every cycle with valid high is one
    // word. Outputs are read at the edge, before the block's own updates of that edge
    // take effect, so the sample always belongs to the cycle that just ended.
    always @(posedge clk)
    begin
        if (rst_n && valid === 1'b1)
            board.check_word('{corner_a, corner_b, corner_c, last, bad_row});
    end

    // ---------------------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------------------

    // Presents one command word and holds it until an edge sees start high with busy low.
    // The caller is at a rising edge; start is left high so back-to-back words need no
    // extra assignment in the same step.
    task automatic send_command(input logic [FACE_BITS-1:0] f, input logic [ROW_BITS-1:0] r);
        start <= 1'b1;
        face  <= f;
        row   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_command(f, r);
    endtask

    // Sender idle cycles: each cycle is skipped with the given chance in a hundred, so
    // gaps of every length land on every phase of a row.
    task automatic idle_sender(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Waits until every expected word has come and the block has dropped busy, then lets
    // the pipeline drain before any register write.
    task automatic settle();
        start <= 1'b0;
        while (board.expected_words.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the edge where psel,
    // penable, pwrite and pready are all high.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (int'(addr >> 2) == REG_DIVISIONS)
            board.set_divisions(data);
    endtask

    // Directed words: reset value of divisions, the field extremes, face wrap, faces with
    // and without the winding swap, zero divisions, saturation above the maximum, junk in
    // the upper data bits and a write to an unmapped register.
    task automatic run_directed();
        // Divisions is still at its reset value of one.
        send_command(5'd0, 5'd0);
        send_command(5'd5, 5'd1);
        send_command(5'd31, 5'd0);
        settle();
        write_reg(ADDR_DIVISIONS, 32'd32);
        send_command(5'd0, 5'd31);
        send_command(5'd19, 5'd31);
        send_command(5'd1, 5'd0);
        send_command(5'd2, 5'd15);
        send_command(5'd8, 5'd7);
        send_command(5'd9, 5'd20);
        send_command(5'd10, 5'd3);
        send_command(5'd11, 5'd30);
        send_command(5'd20, 5'd12);
        send_command(5'd31, 5'd31);
        settle();
        // With zero divisions every row is out of range.
        write_reg(ADDR_DIVISIONS, 32'd0);
        send_command(5'd3, 5'd0);
        send_command(5'd19, 5'd0);
        settle();
        write_reg(ADDR_DIVISIONS, 32'd63);
        send_command(5'd7, 5'd31);
        send_command(5'd14, 5'd31);
        settle();
        // Only the low six bits count, so this is five divisions.
        write_reg(ADDR_DIVISIONS, 32'hFFFF_FFC5);
        send_command(5'd4, 5'd4);
        send_command(5'd6, 5'd5);
        send_command(5'd12, 5'd2);
        settle();
        write_reg(ADDR_UNMAPPED, 32'd2);
        send_command(5'd13, 5'd4);
        send_command(5'd15, 5'd3);
        settle();
    endtask

    // One random stretch at a single divisions setting. Most rows are in range so that
    // whole rows of triangles come out; the rest probe the error word. A tenth of the
    // faces use the wrapping codes above 19.
    task automatic run_random(input int pct, input int div_value, input int count);
        logic [31:0]          data;
        logic [FACE_BITS-1:0] f;
        logic [ROW_BITS-1:0]  r;
        int                   d;
        settle();
        data = ($urandom() & 32'hFFFF_FFC0) | 32'(div_value);
        write_reg(ADDR_DIVISIONS, data);
        d = board.effective_divisions();
        for (int i = 0; i < count; i++)
        begin
            f = ($urandom_range(0, 9) == 0) ? FACE_BITS'($urandom_range(20, 31))
                                            : FACE_BITS'($urandom_range(0, 19));
            if (d > 0 && $urandom_range(0, 99) < 85)
                r = ROW_BITS'($urandom_range(0, d - 1));
            else
                r = ROW_BITS'($urandom_range(0, 31));
            idle_sender(pct);
            send_command(f, r);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Sender idles often at first, then more often, then not at all.
        run_random(28, 32, WORDS_PER_SETTING);
        run_random(28, 3, WORDS_PER_SETTING);
        run_random(52, 1, WORDS_PER_SETTING);
        run_random(52, 17, WORDS_PER_SETTING);
        run_random(0, 63, WORDS_PER_SETTING);
        run_random(0, $urandom_range(2, 31), WORDS_PER_SETTING);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        board.close_out();

        $display("Covered %0d command words (%0d out-of-range rows) over %0d divisions writes.",
                 board.commands, board.bad_rows, board.settings);
        $display("Checked %0d result words with %0d errors.", board.words_checked, board.errors);
        if (board.errors == 0)
            $display("** icosphere_triangle_index_gen_top: PASSED **");
        else
            $display("** icosphere_triangle_index_gen_top: FAILED **");
        $finish;
    end

endmodule
